// ===== rtl/core/tdsa_pkg.sv =====
// Shared constants, codes and controller/datapath interface types.
`timescale 1ns / 1ps
package tdsa_pkg;

	// Geometry
	localparam int MAP_DEPTH = 4096;
	localparam int SLOTS     = 16;
	localparam int TILE_SIDE = 32;
	localparam int TILE_BINS = TILE_SIDE * TILE_SIDE;
	localparam int ACC_DEPTH = SLOTS * TILE_BINS;
	localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
	localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ACC_AW    = SLOT_W + 10;

	// Field widths
	localparam int ACC_W   = 48;
	localparam int MAP_W   = 16;
	localparam int CFG_W   = 32;
	localparam int CFG_AW  = 3;
	localparam int MIDX_W  = 25;
	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

	// Command codes
	localparam logic [1:0] CMD_MAP_WR = 2'd0;
	localparam logic [1:0] CMD_ACCUM  = 2'd1;
	localparam logic [1:0] CMD_DRAIN  = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	// Register indexes
	localparam logic [CFG_AW-1:0] REG_TPC    = 3'd0;
	localparam logic [CFG_AW-1:0] REG_BINS_X = 3'd1;
	localparam logic [CFG_AW-1:0] REG_BINS_Y = 3'd2;
	localparam logic [CFG_AW-1:0] REG_SLOTS  = 3'd3;
	localparam logic [CFG_AW-1:0] REG_SCALE  = 3'd4;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic map_wr;
		logic calc_idx;
		logic map_rd;
		logic acc_rd;
		logic acc_add;
		logic clr_wr;
		logic div_start;
		logic drain_chk;
		logic drain_rd;
		logic mul_hi;
		logic mul_lo;
		logic out_load;
		logic col_inc;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [1:0] cmd;
		logic       acc_go;
		logic       owned;
		logic       div_busy;
		logic       drain_ok;
		logic       clr_last;
		logic       col_last;
		logic       out_busy;
	} dp_stat_t;

endpackage

// ===== rtl/core/tdsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tdsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/tdsa_div.sv =====
// Restoring divider, one quotient bit per cycle: tile number over tiles per column.
`timescale 1ns / 1ps
module tdsa_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [11:0] dividend,
	input  logic [12:0] divisor,
	output logic        busy,
	output logic [11:0] quotient,
	output logic [12:0] remainder
);

	logic [3:0]  cnt_q;
	logic        busy_q;
	logic [11:0] quo_q;
	logic [12:0] rem_q;
	logic [12:0] dvs_q;
	logic [13:0] trial;
	logic        fits;

	// One trial subtraction per step
	assign trial = {rem_q, quo_q[11]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 4'd11;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 4'd1;
			if (cnt_q == 4'd0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[10:0], fits};
			rem_q <= fits ? 13'(trial - {1'b0, dvs_q}) : trial[12:0];
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/core/tdsa_dp.sv =====
// Datapath: registers, lookup and accumulator memories, adder, scaler, output register.
`timescale 1ns / 1ps
module tdsa_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [tdsa_pkg::CFG_AW-1:0] cfg_addr,
	input  logic [tdsa_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic [1:0]                  cmd,
	input  logic [11:0]                 tile_index,
	input  logic [15:0]                 slot,
	input  logic [15:0]                 bin_x,
	input  logic [15:0]                 bin_y,
	input  logic [31:0]                 area,
	input  logic [4:0]                  row_in_tile,
	input  tdsa_pkg::dp_cmd_t           ctl,
	output tdsa_pkg::dp_stat_t          stat,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [15:0]                 out_bin_x,
	output logic [15:0]                 out_bin_y,
	output logic [tdsa_pkg::ACC_W-1:0]  density,
	output logic                        last
);
	import tdsa_pkg::*;

	// Configuration
	logic [12:0] tpc_q;
	logic [15:0] bins_x_q, bins_y_q;
	logic [4:0]  slots_q;
	logic [31:0] scale_q;
	logic [12:0] tpc_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpc_q    <= 13'd1;
			bins_x_q <= 16'hFFFF;
			bins_y_q <= 16'hFFFF;
			slots_q  <= 5'd16;
			scale_q  <= 32'h0001_0000;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_TPC:    tpc_q    <= cfg_wdata[12:0];
				REG_BINS_X: bins_x_q <= cfg_wdata[15:0];
				REG_BINS_Y: bins_y_q <= cfg_wdata[15:0];
				REG_SLOTS:  slots_q  <= cfg_wdata[4:0];
				REG_SCALE:  scale_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Zero tiles per column behaves as one
	assign tpc_eff = (tpc_q == 13'd0) ? 13'd1 : tpc_q;

	// Item registers
	logic [1:0]  cmd_q;
	logic [11:0] tile_q;
	logic [15:0] slot_q, bx_q, by_q;
	logic [31:0] area_q;
	logic [4:0]  row_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= cmd;
			tile_q <= tile_index;
			slot_q <= slot;
			bx_q   <= bin_x;
			by_q   <= bin_y;
			area_q <= area;
			row_q  <= row_in_tile;
		end
	end

	// Tile number of a contribution
	logic [MIDX_W-1:0] midx_q;
	logic [MAP_W-1:0]  map_rdata;
	logic              map_owned;

	always_ff @(posedge clk) begin
		if (ctl.calc_idx) begin
			midx_q <= MIDX_W'(bx_q[15:5] * tpc_eff) + MIDX_W'(by_q[15:5]);
		end
	end

	assign map_owned = (map_rdata < {11'd0, slots_q}) &&
		({1'b0, map_rdata} < 17'(SLOTS));

	tdsa_ram #(.WIDTH(MAP_W), .DEPTH(MAP_DEPTH)) u_map (
		.clk     (clk),
		.wr_en   (ctl.map_wr && ({5'd0, tile_q} < 17'(MAP_DEPTH))),
		.wr_addr (MAP_AW'(tile_q)),
		.wr_data (slot_q),
		.rd_en   (ctl.map_rd),
		.rd_addr (MAP_AW'(midx_q)),
		.rd_data (map_rdata)
	);

	// Clear sweep counter
	logic [ACC_AW-1:0] clr_cnt_q;
	logic              clr_last;

	assign clr_last = clr_cnt_q == ACC_AW'(ACC_DEPTH - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (ctl.clr_wr) begin
			clr_cnt_q <= clr_last ? '0 : clr_cnt_q + 1'b1;
		end
	end

	// Drain geometry from the divider
	logic        div_busy;
	logic [11:0] tile_x;
	logic [12:0] tile_y;
	logic [16:0] gx;
	logic [17:0] y0;
	logic [15:0] span;
	logic        drain_ok_q;
	logic [15:0] gx_q, y0_q;
	logic [5:0]  count_q;
	logic [4:0]  col_q;
	logic        col_last;

	tdsa_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (ctl.div_start),
		.dividend  (tile_q),
		.divisor   (tpc_eff),
		.busy      (div_busy),
		.quotient  (tile_x),
		.remainder (tile_y)
	);

	assign gx   = {tile_x, row_q};
	assign y0   = {tile_y, 5'd0};
	assign span = bins_y_q - y0[15:0];

	always_ff @(posedge clk) begin
		if (ctl.drain_chk) begin
			drain_ok_q <= (slot_q < {11'd0, slots_q}) && ({1'b0, slot_q} < 17'(SLOTS)) &&
				(gx < {1'b0, bins_x_q}) && (y0 < {2'b0, bins_y_q});
			gx_q       <= gx[15:0];
			y0_q       <= y0[15:0];
			count_q    <= (span > 16'd32) ? 6'd32 : span[5:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (ctl.drain_chk) begin
			col_q <= '0;
		end else if (ctl.col_inc) begin
			col_q <= col_q + 5'd1;
		end
	end

	assign col_last = ({1'b0, col_q} + 6'd1) == count_q;

	// Accumulator memory and saturating add
	logic [ACC_AW-1:0] acc_addr_q;
	logic [ACC_AW-1:0] look_addr, drain_addr;
	logic [ACC_W-1:0]  acc_rdata;
	logic [ACC_W:0]    sum;
	logic [ACC_W-1:0]  sum_sat;

	assign look_addr  = {map_rdata[SLOT_W-1:0], bx_q[4:0], by_q[4:0]};
	assign drain_addr = {slot_q[SLOT_W-1:0], row_q, col_q};
	assign sum        = {1'b0, acc_rdata} + {17'd0, area_q};
	assign sum_sat    = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];

	always_ff @(posedge clk) begin
		if (ctl.acc_rd) begin
			acc_addr_q <= look_addr;
		end
	end

	tdsa_ram #(.WIDTH(ACC_W), .DEPTH(ACC_DEPTH)) u_acc (
		.clk     (clk),
		.wr_en   (ctl.clr_wr || ctl.acc_add),
		.wr_addr (ctl.clr_wr ? clr_cnt_q : acc_addr_q),
		.wr_data (ctl.clr_wr ? '0 : sum_sat),
		.rd_en   (ctl.acc_rd || ctl.drain_rd),
		.rd_addr (ctl.drain_rd ? drain_addr : look_addr),
		.rd_data (acc_rdata)
	);

	// Scaling: high and low 24-bit halves through one multiply each cycle
	logic [55:0]      p_hi_s1, p_lo_s2;
	logic [ACC_W:0]   v;
	logic [ACC_W-1:0] v_sat;

	always_ff @(posedge clk) begin
		if (ctl.mul_hi) begin
			p_hi_s1 <= acc_rdata[47:24] * scale_q;
		end
		if (ctl.mul_lo) begin
			p_lo_s2 <= acc_rdata[23:0] * scale_q;
		end
	end

	assign v     = {1'b0, p_hi_s1[39:0], 8'd0} + {9'd0, p_lo_s2[55:16]};
	assign v_sat = ((p_hi_s1[55:40] != 16'd0) || v[ACC_W]) ? ACC_MAX : v[ACC_W-1:0];

	// Output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_bin_x <= gx_q;
			out_bin_y <= y0_q + {11'd0, col_q};
			density   <= v_sat;
			last      <= col_last;
		end
	end

	assign out_valid = out_valid_q;

	// Status
	assign stat.cmd      = cmd_q;
	assign stat.acc_go   = (area_q != 32'd0) && (midx_q < MIDX_W'(MAP_DEPTH));
	assign stat.owned    = map_owned;
	assign stat.div_busy = div_busy;
	assign stat.drain_ok = drain_ok_q;
	assign stat.clr_last = clr_last;
	assign stat.col_last = col_last;
	assign stat.out_busy = out_valid_q && !out_ready;

endmodule

// ===== rtl/core/tdsa_ctrl.sv =====
// Controller: sequences lookup writes, accumulates, drains and clear sweeps.
`timescale 1ns / 1ps
module tdsa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tdsa_pkg::dp_stat_t  stat,
	output tdsa_pkg::dp_cmd_t   ctl
);
	import tdsa_pkg::*;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_DISP, S_AMAP, S_ALOOK, S_AADD,
		S_DDIV, S_DGO, S_DRD, S_DM1, S_DM2, S_DOUT
	} state_t;

	state_t state_q, state_d;

	// Command decode and next state
	always_comb begin
		ctl      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			S_CLR: begin
				ctl.clr_wr = 1'b1;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				case (stat.cmd)
					CMD_MAP_WR: begin
						ctl.map_wr = 1'b1;
						state_d    = S_IDLE;
					end
					CMD_ACCUM: begin
						ctl.calc_idx = 1'b1;
						state_d      = S_AMAP;
					end
					CMD_DRAIN: begin
						ctl.div_start = 1'b1;
						state_d       = S_DDIV;
					end
					default: state_d = S_CLR;
				endcase
			end
			S_AMAP: begin
				ctl.map_rd = stat.acc_go;
				state_d    = stat.acc_go ? S_ALOOK : S_IDLE;
			end
			S_ALOOK: begin
				ctl.acc_rd = stat.owned;
				state_d    = stat.owned ? S_AADD : S_IDLE;
			end
			S_AADD: begin
				ctl.acc_add = 1'b1;
				state_d     = S_IDLE;
			end
			S_DDIV: begin
				if (!stat.div_busy) begin
					ctl.drain_chk = 1'b1;
					state_d       = S_DGO;
				end
			end
			S_DGO: state_d = stat.drain_ok ? S_DRD : S_IDLE;
			S_DRD: begin
				ctl.drain_rd = 1'b1;
				state_d      = S_DM1;
			end
			S_DM1: begin
				ctl.mul_hi = 1'b1;
				state_d    = S_DM2;
			end
			S_DM2: begin
				ctl.mul_lo = 1'b1;
				state_d    = S_DOUT;
			end
			S_DOUT: begin
				if (!stat.out_busy) begin
					ctl.out_load = 1'b1;
					if (stat.col_last) begin
						state_d = S_IDLE;
					end else begin
						ctl.col_inc = 1'b1;
						state_d     = S_DRD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/tiled_density_scatter_accumulate_core.sv =====
// Top level of the tiled density scatter-accumulate core.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | cmd tile_index slot bin_x bin_y area row_in_tile
//  out     | out_valid / out_ready| out_bin_x out_bin_y density last
//  cfg     | cfg_wr_en            | cfg_addr cfg_wdata
//
// One item at a time. A lookup write completes at dispatch; an accumulate reads
// the lookup memory, then does an accumulator read-modify-write; a clear sweeps
// the whole accumulator memory. A drain waits out 12 divider steps, then per column
// does a memory read and two 24x32 multiply steps, up to 32 columns.
// After reset a clearing pass runs before in_ready rises.
// A stalled output holds the drain sequence; a new item is taken once the
// last result of a drain sits in the output register.
`timescale 1ns / 1ps
module tiled_density_scatter_accumulate_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [tdsa_pkg::CFG_AW-1:0] cfg_addr,
	input  logic [tdsa_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  cmd,
	input  logic [11:0]                 tile_index,
	input  logic [15:0]                 slot,
	input  logic [15:0]                 bin_x,
	input  logic [15:0]                 bin_y,
	input  logic [31:0]                 area,
	input  logic [4:0]                  row_in_tile,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [15:0]                 out_bin_x,
	output logic [15:0]                 out_bin_y,
	output logic [tdsa_pkg::ACC_W-1:0]  density,
	output logic                        last
);
	import tdsa_pkg::*;

	dp_cmd_t  ctl;
	dp_stat_t stat;

	tdsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	tdsa_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd),
		.tile_index  (tile_index),
		.slot        (slot),
		.bin_x       (bin_x),
		.bin_y       (bin_y),
		.area        (area),
		.row_in_tile (row_in_tile),
		.ctl         (ctl),
		.stat        (stat),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.out_bin_x   (out_bin_x),
		.out_bin_y   (out_bin_y),
		.density     (density),
		.last        (last)
	);

endmodule

// ===== rtl/core/tdsa_checker.sv =====
// Port-level checker for the scatter-accumulate core, bound to the top level.
`timescale 1ns / 1ps
module tdsa_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [1:0]                  cmd,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [15:0]                 out_bin_x,
	input logic [15:0]                 out_bin_y,
	input logic [tdsa_pkg::ACC_W-1:0]  density,
	input logic                        last
);
	import tdsa_pkg::*;

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(density) &&
		$stable(out_bin_x) && $stable(out_bin_y) && $stable(last))
		else $error("stalled result changed");

	// One item at a time: no transfer in the cycle after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken back to back");

	// Only a drain produces results
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (cmd != CMD_DRAIN) |=> !$rose(out_valid))
		else $error("result without a drain");

	// A drain does not raise a result too early
	a_drain_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (cmd == CMD_DRAIN) |=> ##2 !$rose(out_valid))
		else $error("drain result too early");

endmodule

bind tiled_density_scatter_accumulate_core tdsa_checker u_tdsa_checker (.*);

// ===== bench/testbench.sv =====
// Self-checking testbench for the tiled density scatter-accumulate core.
`timescale 1ns / 1ps
module testbench;
	import tdsa_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;

	typedef struct packed {
		logic [15:0]      bx;
		logic [15:0]      by;
		logic [ACC_W-1:0] dens;
		logic             lst;
	} bin_value_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = '0;
	logic [CFG_W-1:0]  cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        cmd = CMD_CLEAR;
	logic [11:0]       tile_index = '0;
	logic [15:0]       slot = '0;
	logic [15:0]       bin_x = '0;
	logic [15:0]       bin_y = '0;
	logic [31:0]       area = '0;
	logic [4:0]        row_in_tile = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [15:0]       out_bin_x;
	logic [15:0]       out_bin_y;
	logic [ACC_W-1:0]  density;
	logic              last;

	tiled_density_scatter_accumulate_core u_top (.*);

	// Shadow copy of the block state
	logic [15:0]      slot_map [MAP_DEPTH];
	bit               map_written [MAP_DEPTH];
	logic [ACC_W-1:0] bin_acc [ACC_DEPTH];
	logic [12:0]      tpc_reg;
	logic [15:0]      bins_x_reg, bins_y_reg;
	logic [4:0]       slots_reg;
	logic [31:0]      scale_reg;

	bin_value_t pending_bins [$];
	int         mismatches = 0;
	int         cycles = 0;
	bit         gaps_on = 1'b1;

	initial begin
		forever #1 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [12:0] tpc_eff();
		return (tpc_reg == 0) ? 13'd1 : tpc_reg;
	endfunction

	// Q16.16 drain scaling, split into 24-bit halves, saturated
	function automatic logic [ACC_W-1:0] scale_bin(logic [ACC_W-1:0] acc, logic [31:0] s);
		logic [63:0] p_hi, p_lo, v;
		p_hi = {40'd0, acc[47:24]} * {32'd0, s};
		p_lo = {40'd0, acc[23:0]} * {32'd0, s};
		if (p_hi >= (64'd1 << 40)) return ACC_MAX;
		v = (p_hi << 8) + (p_lo >> 16);
		return (v > {16'd0, ACC_MAX}) ? ACC_MAX : v[ACC_W-1:0];
	endfunction

	// Update the shadow state for one transfer and queue drain results
	task automatic predict_item(logic [1:0] c, logic [11:0] ti, logic [15:0] sl,
			logic [15:0] bx, logic [15:0] by, logic [31:0] ar, logic [4:0] row);
		int unsigned midx, loc, idx, tx, ty, gx, y0, cnt;
		logic [48:0] sum;
		bin_value_t bv;
		case (c)
			CMD_MAP_WR: begin
				slot_map[ti] = sl;
				map_written[ti] = 1'b1;
			end
			CMD_CLEAR: foreach (bin_acc[i]) bin_acc[i] = '0;
			CMD_ACCUM: begin
				if (ar != 0) begin
					midx = (bx >> 5) * tpc_eff() + (by >> 5);
					if (midx < MAP_DEPTH) begin
						loc = slot_map[midx];
						if (loc < slots_reg && loc < SLOTS) begin
							idx = loc * TILE_BINS + (bx & 31) * 32 + (by & 31);
							sum = {1'b0, bin_acc[idx]} + ar;
							bin_acc[idx] = sum[48] ? ACC_MAX : sum[47:0];
						end
					end
				end
			end
			default: begin
				if (sl < slots_reg && sl < SLOTS) begin
					tx = ti / tpc_eff();
					ty = ti % tpc_eff();
					gx = tx * 32 + row;
					y0 = ty * 32;
					if (gx < bins_x_reg && y0 < bins_y_reg) begin
						cnt = bins_y_reg - y0;
						if (cnt > 32) cnt = 32;
						for (int k = 0; k < cnt; k++) begin
							bv.bx = gx[15:0];
							bv.by = y0[15:0] + k[15:0];
							bv.dens = scale_bin(bin_acc[sl * TILE_BINS + row * 32 + k], scale_reg);
							bv.lst = (k + 1 == cnt);
							pending_bins.push_back(bv);
						end
					end
				end
			end
		endcase
	endtask

	// One input transfer; valid stays high across back-to-back items
	task automatic send_item(logic [1:0] c, logic [11:0] ti, logic [15:0] sl,
			logic [15:0] bx, logic [15:0] by, logic [31:0] ar, logic [4:0] row);
		int g;
		in_valid <= 1'b1;
		cmd <= c;
		tile_index <= ti;
		slot <= sl;
		bin_x <= bx;
		bin_y <= by;
		area <= ar;
		row_in_tile <= row;
		do @(posedge clk); while (!in_ready);
		predict_item(c, ti, sl, bx, by, ar, row);
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Wait for the block to go idle: results drained, clears finished
	task automatic settle();
		@(posedge clk);
		in_valid <= 1'b0;
		while (pending_bins.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		while (!in_ready) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Write enable stays high across a run of writes
	task automatic write_reg(logic [CFG_AW-1:0] a, logic [31:0] d);
		cfg_wr_en <= 1'b1;
		cfg_addr <= a;
		cfg_wdata <= d;
		@(posedge clk);
		case (a)
			REG_TPC:    tpc_reg = d[12:0];
			REG_BINS_X: bins_x_reg = d[15:0];
			REG_BINS_Y: bins_y_reg = d[15:0];
			REG_SLOTS:  slots_reg = d[4:0];
			default:    scale_reg = d;
		endcase
	endtask

	task automatic set_config(logic [12:0] t, logic [15:0] x, logic [15:0] y,
			logic [4:0] s, logic [31:0] sc);
		settle();
		write_reg(REG_TPC, 32'(t));
		write_reg(REG_BINS_X, 32'(x));
		write_reg(REG_BINS_Y, 32'(y));
		write_reg(REG_SLOTS, 32'(s));
		write_reg(REG_SCALE, sc);
		cfg_wr_en <= 1'b0;
	endtask

	// Result checker and output stall generator
	always @(posedge clk) begin : result_check
		static int stall = 0;
		bin_value_t e;
		if (out_valid && out_ready) begin
			if (pending_bins.size() == 0) begin
				$error("unexpected result x=%0d y=%0d", out_bin_x, out_bin_y);
				mismatches++;
			end else begin
				e = pending_bins.pop_front();
				if (out_bin_x !== e.bx) begin
					$error("out_bin_x: expected %0d, got %0d", e.bx, out_bin_x);
					mismatches++;
				end
				if (out_bin_y !== e.by) begin
					$error("out_bin_y: expected %0d, got %0d", e.by, out_bin_y);
					mismatches++;
				end
				if (density !== e.dens) begin
					$error("density: expected %0h, got %0h", e.dens, density);
					mismatches++;
				end
				if (last !== e.lst) begin
					$error("last: expected %0d, got %0d", e.lst, last);
					mismatches++;
				end
			end
		end
		if (stall > 0) begin
			out_ready <= 1'b0;
			stall--;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 99) < 25) stall = pick_gap();
		end
	end

	// Seed the first lookup entries; later accumulates only hit written entries
	task automatic test_map_fill();
		for (int i = 0; i < 12; i++)
			send_item(CMD_MAP_WR, i[11:0],
				($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 15)) : 16'($urandom),
				16'd0, 16'd0, 32'd0, 5'd0);
	endtask

	// Directed corners of the drop rules and drain clipping
	task automatic test_directed();
		set_config(13'd1, 16'hFFFF, 16'hFFFF, 5'd16, 32'h0001_0000);
		send_item(CMD_MAP_WR, 12'd0, 16'd2, 0, 0, 0, 0);
		send_item(CMD_MAP_WR, 12'd1, 16'hFFFF, 0, 0, 0, 0);
		send_item(CMD_MAP_WR, 12'd4095, 16'd15, 0, 0, 0, 0);
		send_item(CMD_ACCUM, 0, 0, 16'd3, 16'd7, 32'hFFFF_FFFF, 0);
		send_item(CMD_ACCUM, 0, 0, 16'd3, 16'd8, 32'd0, 0);           // padding
		send_item(CMD_ACCUM, 0, 0, 16'd0, 16'd33, 32'd5, 0);          // unowned slot
		send_item(CMD_ACCUM, 0, 0, 16'd3, 16'd31, 32'd1, 0);
		send_item(CMD_DRAIN, 12'd0, 16'd2, 0, 0, 0, 5'd3);
		send_item(CMD_DRAIN, 12'd0, 16'd16, 0, 0, 0, 5'd3);           // slot beyond SLOTS
		send_item(CMD_DRAIN, 12'd4095, 16'd15, 0, 0, 0, 5'd31);
		set_config(13'd0, 16'd4, 16'd40, 5'd3, 32'hFFFF_FFFF);        // zero tiles per column
		send_item(CMD_DRAIN, 12'd0, 16'd2, 0, 0, 0, 5'd3);            // saturated scale, clipped
		send_item(CMD_DRAIN, 12'd0, 16'd2, 0, 0, 0, 5'd4);            // row outside grid
		send_item(CMD_DRAIN, 12'd2, 16'd2, 0, 0, 0, 5'd0);            // tile outside grid
		send_item(CMD_DRAIN, 12'd0, 16'd3, 0, 0, 0, 5'd0);            // slot not in use
		set_config(13'd4096, 16'd1, 16'd1, 5'd0, 32'd0);
		send_item(CMD_ACCUM, 0, 0, 16'd0, 16'd0, 32'd7, 0);
		send_item(CMD_ACCUM, 0, 0, 16'd32, 16'd0, 32'd9, 0);          // beyond table
		send_item(CMD_DRAIN, 12'd0, 16'd2, 0, 0, 0, 5'd0);
		set_config(13'd1, 16'hFFFF, 16'hFFFF, 5'd16, 32'd0);
		send_item(CMD_DRAIN, 12'd0, 16'd2, 0, 0, 0, 5'd3);            // zero scale
		send_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
		send_item(CMD_DRAIN, 12'd0, 16'd2, 0, 0, 0, 5'd3);
	endtask

	// Mostly accumulate-then-drain on owned tiles, with some noise mixed in
	task automatic random_phase(int n);
		int unsigned tx, ty, t, r, xmax, ymax, nm;
		logic [15:0] nbx, nby;
		for (int i = 0; i < n; i++) begin
			xmax = (bins_x_reg - 1) / 32;
			if (xmax > 2047) xmax = 2047;
			ymax = (bins_y_reg - 1) / 32;
			if (ymax > tpc_eff() - 1) ymax = tpc_eff() - 1;
			tx = $urandom_range(0, xmax);
			ty = $urandom_range(0, ymax);
			t = tx * tpc_eff() + ty;
			if (t >= MAP_DEPTH) t = $urandom_range(0, MAP_DEPTH - 1);
			tx = t / tpc_eff();
			ty = t % tpc_eff();
			r = $urandom_range(0, 99);
			if (r < 55 && tx < 2048 && ty < 2048) begin
				if (map_written[t])
					send_item(CMD_ACCUM, 0, 0, 16'(tx * 32 + $urandom_range(0, 31)),
						16'(ty * 32 + $urandom_range(0, 31)),
						($urandom_range(0, 3) == 0) ? 32'($urandom) :
						32'($urandom_range(1, 1 << 20)),
						0);
				else
					send_item(CMD_MAP_WR, t[11:0], 16'($urandom_range(0, 17)), 0, 0, 0, 0);
			end else if (r < 80)
				send_item(CMD_DRAIN, t[11:0], slot_map[t], 0, 0, 0, 5'($urandom));
			else if (r < 88)
				send_item(CMD_MAP_WR, 12'($urandom), 16'($urandom_range(0, 17)), 16'($urandom),
					16'($urandom), 32'($urandom), 5'($urandom));
			else if (r < 94) begin
				nbx = 16'($urandom);
				nby = 16'($urandom);
				nm = (nbx >> 5) * tpc_eff() + (nby >> 5);
				if (nm < MAP_DEPTH && !map_written[nm])
					send_item(CMD_MAP_WR, nm[11:0], 16'($urandom_range(0, 17)), 0, 0, 0, 0);
				else
					send_item(CMD_ACCUM, 12'($urandom), 16'($urandom), nbx,
						nby, 32'($urandom), 5'($urandom));
			end else
				send_item(CMD_DRAIN, 12'($urandom), 16'($urandom_range(0, 20)), 16'($urandom),
					16'($urandom), 32'($urandom), 5'($urandom));
		end
	endtask

	task automatic test_random();
		set_config(13'd1, 16'hFFFF, 16'hFFFF, 5'd16, 32'h0001_0000);
		random_phase(15);
		set_config(13'd64, 16'd1000, 16'd100, 5'd5, 32'($urandom));
		random_phase(15);
		gaps_on = 1'b0;
		set_config(13'd8191, 16'd70, 16'd65535, 5'd31, 32'hFFFF_FFFF);
		random_phase(15);
		gaps_on = 1'b1;
		set_config(13'd3, 16'd65535, 16'd90, 5'd16, 32'd1);
		send_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
		random_phase(15);
		set_config(13'd4096, 16'd200, 16'd1, 5'd9, 32'h0000_8000);
		random_phase(15);
	endtask

	initial begin
		tpc_reg = 13'd1;
		bins_x_reg = 16'hFFFF;
		bins_y_reg = 16'hFFFF;
		slots_reg = 5'd16;
		scale_reg = 32'h0001_0000;
		foreach (bin_acc[i]) bin_acc[i] = '0;
		foreach (slot_map[i]) slot_map[i] = '0;
		foreach (map_written[i]) map_written[i] = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_map_fill();
		test_directed();
		test_random();
		settle();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && pending_bins.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
